@@ src/mbrc_pkg.sv @@
// Shared types, codes and helpers of the Modbus RTU response checker.
// Used by every module of the block; depends on nothing else.

package mbrc_pkg;

	// Largest buffer the design supports and the default buffer size.
	localparam int MAX_REG_LIMIT   = 64;
	localparam int MAX_REGISTERS_D = 32;

	// Width of a register count carried in a job (holds up to MAX_REG_LIMIT).
	localparam int CNT_W = 7;

	// Width of a value buffer address carried between front and back.
	localparam int MEM_ADDR_W = 6;

	// Depth of the job queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_SLAVE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REQUEST_FUNCTION = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_REGISTER   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REQUEST_COUNT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WRITTEN_VALUE    = 3'd4;

	// Modbus function codes handled by the checker.
	localparam logic [7:0] FN_READ_HOLDING = 8'd3;
	localparam logic [7:0] FN_WRITE_SINGLE = 8'd6;
	localparam logic [7:0] FN_WRITE_MULTI  = 8'd16;

	// Modbus CRC-16, reflected form.
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_MISMATCH    = 3'd1,
		ST_CRC         = 3'd2,
		ST_UNSUPPORTED = 3'd3,
		ST_TOO_MANY    = 3'd4
	} status_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SINGLE,
		BK_READ,
		BK_BURST
	} back_state_t;

	// Request held in the configuration registers.
	typedef struct packed {
		logic [7:0]  expected_slave;
		logic [7:0]  request_function;
		logic [15:0] start_register;
		logic [15:0] request_count;
		logic [15:0] written_value;
	} cfg_t;

	// One job handed from front to back. A burst job reads count values from the
	// buffer, numbering them from reg_number; any other job gives one result.
	typedef struct packed {
		status_t          status;
		logic [7:0]       slave;
		logic [15:0]      reg_number;
		logic [15:0]      reg_value;
		logic             burst;
		logic [CNT_W-1:0] count;
	} job_t;

	// Write into the value buffer.
	typedef struct packed {
		logic                  en;
		logic [MEM_ADDR_W-1:0] addr;
		logic [15:0]           data;
	} mem_wr_t;

	// Fold one byte into the running CRC, one bit per step.
	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ src/mbrc_fifo.sv @@
// Short job queue between the parsing front and the result back end.
// Depends on mbrc_pkg for the job type and the queue depth.

module mbrc_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mbrc_pkg::job_t push_job,
	input  logic          pop,
	output mbrc_pkg::job_t pop_job,
	output logic          full,
	output logic          empty
);

	localparam int DEPTH = mbrc_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mbrc_pkg::job_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	logic do_push;
	logic do_pop;

	assign full    = (fill_q == CNT_W'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = entry_q[rd_ptr_q];

	// Storage for queued jobs.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

@@ src/mbrc_front.sv @@
// Front end: takes response bytes, tracks the frame, runs the CRC, fills the
// value buffer and queues one job per frame. Depends on mbrc_pkg.

module mbrc_front #(
	parameter int MAX_REGISTERS = mbrc_pkg::MAX_REGISTERS_D
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mbrc_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_start,
	input  logic              queue_full,
	output logic              push,
	output mbrc_pkg::job_t    push_job,
	output mbrc_pkg::mem_wr_t mem_wr,
	input  logic              burst_done
);

	logic [7:0]  pos_q,   pos_d;
	logic [15:0] crc_q,   crc_d;
	logic [7:0]  slave_q, slave_d;
	logic [7:0]  func_q,  func_d;
	logic [7:0]  bc_q,    bc_d;
	logic [15:0] fa_q,    fa_d;
	logic [15:0] fb_q,    fb_d;
	logic [7:0]  rcrc_lo_q, rcrc_lo_d;
	logic [7:0]  hi_q,    hi_d;
	logic        skip_q,  skip_d;
	logic        burst_q;

	logic           accept;
	logic [7:0]     p;
	logic [15:0]    crc_c;
	logic           skip_c;
	logic [15:0]    crc_next;
	logic           is_read;
	logic [7:0]     bc_c;
	logic [8:0]     len_m2;
	logic [7:0]     off;
	mbrc_pkg::job_t fin_job;
	mbrc_pkg::job_t one_job;

	assign is_read = (func_q == mbrc_pkg::FN_READ_HOLDING);

	// A burst still draining owns the buffer: hold off the data bytes of a read.
	assign in_ready = !queue_full && !(burst_q && is_read && !skip_q && (pos_q >= 8'd2));
	assign accept   = in_valid && in_ready;

	// A frame start restarts the parse before the byte is looked at.
	assign p        = in_start ? 8'd0 : pos_q;
	assign crc_c    = in_start ? mbrc_pkg::CRC_INIT : crc_q;
	assign skip_c   = in_start ? 1'b0 : skip_q;
	assign crc_next = mbrc_pkg::crc_add(crc_c, in_byte);

	assign bc_c   = (is_read && (p == 8'd2)) ? in_byte : bc_q;
	assign len_m2 = is_read ? (9'd3 + {1'b0, bc_c}) : 9'd6;
	assign off    = p - 8'd3;

	// Outcome of a complete frame, checked on its final CRC byte.
	always_comb begin
		logic id_ok;
		id_ok = (slave_q == cfg.expected_slave) && (func_q == cfg.request_function);
		fin_job            = '0;
		fin_job.slave      = slave_q;
		fin_job.status     = mbrc_pkg::ST_MISMATCH;
		if (crc_c != {in_byte, rcrc_lo_q}) begin
			fin_job.status = mbrc_pkg::ST_CRC;
		end else if (is_read) begin
			if (id_ok && ({cfg.request_count, 1'b0} == {9'd0, bc_q})) begin
				fin_job.status = mbrc_pkg::ST_OK;
				if (bc_q[7:1] != 7'd0) begin
					fin_job.burst      = 1'b1;
					fin_job.count      = mbrc_pkg::CNT_W'(bc_q[7:1]);
					fin_job.reg_number = cfg.start_register;
				end
			end
		end else if (func_q == mbrc_pkg::FN_WRITE_SINGLE) begin
			if (id_ok && (fa_q == cfg.start_register) && (fb_q == cfg.written_value)) begin
				fin_job.status     = mbrc_pkg::ST_OK;
				fin_job.reg_number = fa_q;
				fin_job.reg_value  = fb_q;
			end
		end else begin
			if (id_ok && (fa_q == cfg.start_register) && (fb_q == cfg.request_count)) begin
				fin_job.status = mbrc_pkg::ST_OK;
			end
		end
	end

	// Byte parser: next register values, job push and buffer writes.
	always_comb begin
		pos_d     = pos_q;
		crc_d     = crc_q;
		slave_d   = slave_q;
		func_d    = func_q;
		bc_d      = bc_q;
		fa_d      = fa_q;
		fb_d      = fb_q;
		rcrc_lo_d = rcrc_lo_q;
		hi_d      = hi_q;
		skip_d    = skip_q;
		push      = 1'b0;
		push_job  = '0;
		one_job   = '0;
		mem_wr    = '0;
		one_job.slave = slave_q;
		if (accept) begin
			pos_d  = p;
			crc_d  = crc_c;
			skip_d = skip_c;
			if (!skip_c) begin
				if (p == 8'd0) begin
					slave_d = in_byte;
					crc_d   = crc_next;
					pos_d   = 8'd1;
				end else if (p == 8'd1) begin
					func_d = in_byte;
					crc_d  = crc_next;
					if (in_byte inside {mbrc_pkg::FN_READ_HOLDING, mbrc_pkg::FN_WRITE_SINGLE,
							mbrc_pkg::FN_WRITE_MULTI}) begin
						pos_d = 8'd2;
					end else begin
						skip_d         = 1'b1;
						push           = 1'b1;
						push_job       = one_job;
						push_job.status = mbrc_pkg::ST_UNSUPPORTED;
					end
				end else if (is_read && (p == 8'd2) &&
						({1'b0, in_byte[7:1]} > 8'(MAX_REGISTERS))) begin
					bc_d            = in_byte;
					skip_d          = 1'b1;
					push            = 1'b1;
					push_job        = one_job;
					push_job.status = mbrc_pkg::ST_TOO_MANY;
				end else begin
					bc_d  = bc_c;
					pos_d = p + 8'd1;
					if ({1'b0, p} < len_m2) begin
						crc_d = crc_next;
						if (is_read) begin
							if (p >= 8'd3) begin
								if (!off[0]) begin
									hi_d = in_byte;
								end else if ({1'b0, off[7:1]} < 8'(MAX_REGISTERS)) begin
									mem_wr.en   = 1'b1;
									mem_wr.addr = off[mbrc_pkg::MEM_ADDR_W:1];
									mem_wr.data = {hi_q, in_byte};
								end
							end
						end else begin
							case (p)
								8'd2:    fa_d = {in_byte, 8'h00};
								8'd3:    fa_d = {fa_q[15:8], in_byte};
								8'd4:    fb_d = {in_byte, 8'h00};
								default: fb_d = {fb_q[15:8], in_byte};
							endcase
						end
					end else if ({1'b0, p} == len_m2) begin
						rcrc_lo_d = in_byte;
					end else begin
						skip_d   = 1'b1;
						push     = 1'b1;
						push_job = fin_job;
					end
				end
			end
		end
	end

	// Parse state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= mbrc_pkg::CRC_INIT;
			slave_q   <= '0;
			func_q    <= '0;
			bc_q      <= '0;
			fa_q      <= '0;
			fb_q      <= '0;
			rcrc_lo_q <= '0;
			skip_q    <= 1'b0;
			burst_q   <= 1'b0;
		end else begin
			pos_q     <= pos_d;
			crc_q     <= crc_d;
			slave_q   <= slave_d;
			func_q    <= func_d;
			bc_q      <= bc_d;
			fa_q      <= fa_d;
			fb_q      <= fb_d;
			rcrc_lo_q <= rcrc_lo_d;
			skip_q    <= skip_d;
			if (push && push_job.burst) begin
				burst_q <= 1'b1;
			end else if (burst_done) begin
				burst_q <= 1'b0;
			end
		end
	end

	// High byte of the register value being assembled.
	always_ff @(posedge clk) begin
		hi_q <= hi_d;
	end

endmodule

@@ src/mbrc_back.sv @@
// Back end: takes jobs from the queue, reads the value buffer for reads and
// drives the registered result stream. Depends on mbrc_pkg.

module mbrc_back #(
	parameter int MAX_REGISTERS = mbrc_pkg::MAX_REGISTERS_D
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mbrc_pkg::job_t    job,
	input  logic              queue_empty,
	output logic              pop,
	input  mbrc_pkg::mem_wr_t mem_wr,
	output logic              burst_done,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        out_status,
	output logic [7:0]        out_slave,
	output logic [15:0]       out_reg_number,
	output logic [15:0]       out_reg_value,
	output logic              out_last
);

	localparam int IDX_W = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;

	logic [15:0] value_mem [MAX_REGISTERS];

	mbrc_pkg::back_state_t state_q, state_d;
	mbrc_pkg::job_t        cur_q;
	logic [mbrc_pkg::CNT_W-1:0] cnt_q;
	logic [15:0]           rd_q;

	logic slot_free;
	logic is_last;
	logic load_single;
	logic load_burst;

	assign slot_free = !out_valid || out_ready;
	assign is_last   = ((cnt_q + 1'b1) == cur_q.count);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mbrc_pkg::BK_IDLE: begin
				if (!queue_empty) begin
					state_d = job.burst ? mbrc_pkg::BK_READ : mbrc_pkg::BK_SINGLE;
				end
			end
			mbrc_pkg::BK_SINGLE: begin
				if (slot_free) begin
					state_d = mbrc_pkg::BK_IDLE;
				end
			end
			mbrc_pkg::BK_READ: begin
				state_d = mbrc_pkg::BK_BURST;
			end
			mbrc_pkg::BK_BURST: begin
				if (slot_free) begin
					state_d = is_last ? mbrc_pkg::BK_IDLE : mbrc_pkg::BK_READ;
				end
			end
			default: state_d = mbrc_pkg::BK_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		pop         = 1'b0;
		load_single = 1'b0;
		load_burst  = 1'b0;
		case (state_q)
			mbrc_pkg::BK_IDLE:   pop         = !queue_empty;
			mbrc_pkg::BK_SINGLE: load_single = slot_free;
			mbrc_pkg::BK_BURST:  load_burst  = slot_free;
			default: ;
		endcase
		burst_done = load_burst && is_last;
	end

	// Value buffer: written by the front, read one word a cycle here.
	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			value_mem[mem_wr.addr[IDX_W-1:0]] <= mem_wr.data;
		end
		rd_q <= value_mem[cnt_q[IDX_W-1:0]];
	end

	// Current job.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= job;
		end
	end

	// Sequencer state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mbrc_pkg::BK_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				cnt_q <= '0;
			end else if (load_burst) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (load_single || load_burst) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load_single) begin
			out_status     <= cur_q.status;
			out_slave      <= cur_q.slave;
			out_reg_number <= cur_q.reg_number;
			out_reg_value  <= cur_q.reg_value;
			out_last       <= 1'b1;
		end else if (load_burst) begin
			out_status     <= mbrc_pkg::ST_OK;
			out_slave      <= cur_q.slave;
			out_reg_number <= cur_q.reg_number + 16'(cnt_q);
			out_reg_value  <= rd_q;
			out_last       <= is_last;
		end
	end

endmodule

@@ src/modbus_rtu_response_checker.sv @@
// Top level of the Modbus RTU response checker: configuration registers,
// front end, job queue and back end. Depends on mbrc_pkg and its submodules.
//
// The checker takes a slave's response one byte per transaction, with tuser
// high on the first byte of a frame, checks the Modbus CRC-16 and the echoed
// fields against the request in the configuration registers, and gives one
// result per register read for a good function 3 frame and one result for
// anything else. The front end takes one byte per cycle while the queue has
// room. The back end takes a job from the queue in its idle state, then loads
// a single result once the output slot is free, or for a read steps through a
// buffer read and then the output load for each register. Up to two finished
// frames wait in the queue between the front and the back. While the registers
// of a read are being delivered, the byte count and data bytes of a following
// read frame are held off, as both share the one value buffer. Configuration is
// to be written only while the checker is idle; the block does not enforce it.

module modbus_rtu_response_checker #(
	parameter int MAX_REGISTERS = mbrc_pkg::MAX_REGISTERS_D
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mbrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
	input  logic                           s_axis_tuser,  // [0] frame_start
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [39:0]                    m_axis_tdata,  // [7:0] slave_id,
	                                                      // [23:8] reg_number,
	                                                      // [39:24] reg_value
	output logic [2:0]                     m_axis_tuser,  // [2:0] status
	output logic                           m_axis_tlast
);

	mbrc_pkg::cfg_t    cfg_q;
	mbrc_pkg::job_t    push_job;
	mbrc_pkg::job_t    pop_job;
	mbrc_pkg::mem_wr_t mem_wr;
	logic              push;
	logic              pop;
	logic              queue_full;
	logic              queue_empty;
	logic              burst_done;
	logic [7:0]        res_slave;
	logic [15:0]       res_reg_number;
	logic [15:0]       res_reg_value;

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_slave   <= 8'd1;
			cfg_q.request_function <= mbrc_pkg::FN_READ_HOLDING;
			cfg_q.start_register   <= 16'd0;
			cfg_q.request_count    <= 16'd1;
			cfg_q.written_value    <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				mbrc_pkg::REG_EXPECTED_SLAVE:   cfg_q.expected_slave   <= cfg_data[7:0];
				mbrc_pkg::REG_REQUEST_FUNCTION: cfg_q.request_function <= cfg_data[7:0];
				mbrc_pkg::REG_START_REGISTER:   cfg_q.start_register   <= cfg_data;
				mbrc_pkg::REG_REQUEST_COUNT:    cfg_q.request_count    <= cfg_data;
				mbrc_pkg::REG_WRITTEN_VALUE:    cfg_q.written_value    <= cfg_data;
				default: ;
			endcase
		end
	end

	mbrc_front #(
		.MAX_REGISTERS(MAX_REGISTERS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.in_start   (s_axis_tuser),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job),
		.mem_wr     (mem_wr),
		.burst_done (burst_done)
	);

	mbrc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	mbrc_back #(
		.MAX_REGISTERS(MAX_REGISTERS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job            (pop_job),
		.queue_empty    (queue_empty),
		.pop            (pop),
		.mem_wr         (mem_wr),
		.burst_done     (burst_done),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_status     (m_axis_tuser),
		.out_slave      (res_slave),
		.out_reg_number (res_reg_number),
		.out_reg_value  (res_reg_value),
		.out_last       (m_axis_tlast)
	);

	// Result fields packed from the lowest bit up.
	assign m_axis_tdata = {res_reg_value, res_reg_number, res_slave};

endmodule

@@ dv/modbus_rtu_response_checker_tb.sv @@
// Self-checking testbench for the Modbus RTU response checker: drives response
// bytes with valid CRCs and injected faults, predicts every result in the bench.
// Depends on mbrc_pkg and modbus_rtu_response_checker.

module modbus_rtu_response_checker_tb;

	localparam int MAX_REGS = mbrc_pkg::MAX_REGISTERS_D;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 500;
	localparam int SETTLE_CYCLES = 24;
	// Index past the end of the register list; writes to it must be ignored.
	localparam logic [mbrc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
	} rx_item_t;

	typedef struct packed {
		mbrc_pkg::status_t status;
		logic [7:0]        slave;
		logic [15:0]       reg_num;
		logic [15:0]       reg_val;
		logic              last;
	} result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [mbrc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]                    cfg_data = '0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [7:0]                     s_axis_tdata = '0;   // [7:0] rx_byte
	logic                           s_axis_tuser = 1'b0; // [0] frame_start
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [39:0]                    m_axis_tdata;        // [7:0] slave_id,
	                                                     // [23:8] reg_number,
	                                                     // [39:24] reg_value
	logic [2:0]                     m_axis_tuser;        // [2:0] status
	logic                           m_axis_tlast;

	modbus_rtu_response_checker u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Clock with a period of 20.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Bytes waiting to be offered, and results the prediction still owes.
	rx_item_t   rx_queue[$];
	result_t    due_results[$];
	logic [7:0] frame_body[$];
	int         errors = 0;
	int         stim_count = 0;
	int         cycle_count = 0;
	int         hold_left = 0;
	bit         hold_go = 1'b0;
	bit         hold_used = 1'b0;
	result_t    seen_want;

	// Request as the predictor sees it, starting from the reset values.
	logic [7:0]  cfg_slave = 8'd1;
	logic [7:0]  cfg_func = mbrc_pkg::FN_READ_HOLDING;
	logic [15:0] cfg_start = 16'd0;
	logic [15:0] cfg_count = 16'd1;
	logic [15:0] cfg_value = 16'd0;

	// Parser state of the predictor.
	int          pos = 0;
	logic [15:0] crc_run = mbrc_pkg::CRC_INIT;
	logic [7:0]  rx_slave = '0;
	logic [7:0]  rx_func = '0;
	logic [7:0]  rx_count = '0;
	logic [15:0] echo_a = '0;
	logic [15:0] echo_b = '0;
	logic [15:0] rx_crc = '0;
	logic [15:0] reg_buf[MAX_REGS];
	bit          ignoring = 1'b0;

	// Modbus CRC-16, least significant bit first.
	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			fb = c[0];
			c = {1'b0, c[15:1]};
			if (fb)
				c = c ^ mbrc_pkg::CRC_POLY;
		end
		return c;
	endfunction

	task automatic post_result(input mbrc_pkg::status_t st, input logic [15:0] num,
			input logic [15:0] val, input logic last);
		due_results.push_back('{status: st, slave: rx_slave, reg_num: num, reg_val: val,
			last: last});
	endtask

	// Frame complete: CRC first, then the echoed fields against the request.
	task automatic close_frame();
		logic good;
		int   n;
		ignoring = 1'b1;
		if (crc_run != rx_crc) begin
			post_result(mbrc_pkg::ST_CRC, 16'd0, 16'd0, 1'b1);
			return;
		end
		good = (rx_slave == cfg_slave) && (rx_func == cfg_func);
		if (rx_func == mbrc_pkg::FN_READ_HOLDING) begin
			good = good && (int'(cfg_count) * 2 == int'(rx_count));
			if (!good) begin
				post_result(mbrc_pkg::ST_MISMATCH, 16'd0, 16'd0, 1'b1);
				return;
			end
			n = int'(rx_count) >> 1;
			if (n > MAX_REGS)
				n = MAX_REGS;
			if (n == 0) begin
				post_result(mbrc_pkg::ST_OK, 16'd0, 16'd0, 1'b1);
				return;
			end
			for (int i = 0; i < n; i++)
				post_result(mbrc_pkg::ST_OK, 16'(cfg_start + i), reg_buf[i], i == n - 1);
		end else if (rx_func == mbrc_pkg::FN_WRITE_SINGLE) begin
			if (good && echo_a == cfg_start && echo_b == cfg_value)
				post_result(mbrc_pkg::ST_OK, echo_a, echo_b, 1'b1);
			else
				post_result(mbrc_pkg::ST_MISMATCH, 16'd0, 16'd0, 1'b1);
		end else begin
			good = good && echo_a == cfg_start && echo_b == cfg_count;
			post_result(good ? mbrc_pkg::ST_OK : mbrc_pkg::ST_MISMATCH, 16'd0, 16'd0, 1'b1);
		end
	endtask

	// Predict the effect of one accepted response byte.
	task automatic absorb_byte(input logic [7:0] b, input logic first);
		int p;
		int len;
		int idx;
		if (first) begin
			pos = 0;
			crc_run = mbrc_pkg::CRC_INIT;
			ignoring = 1'b0;
		end
		if (ignoring)
			return;
		p = pos;
		if (p == 0) begin
			rx_slave = b;
			crc_run = crc16_next(crc_run, b);
			pos = 1;
			return;
		end
		if (p == 1) begin
			rx_func = b;
			crc_run = crc16_next(crc_run, b);
			if (!(b inside {mbrc_pkg::FN_READ_HOLDING, mbrc_pkg::FN_WRITE_SINGLE,
					mbrc_pkg::FN_WRITE_MULTI})) begin
				ignoring = 1'b1;
				post_result(mbrc_pkg::ST_UNSUPPORTED, 16'd0, 16'd0, 1'b1);
				return;
			end
			pos = 2;
			return;
		end
		if (rx_func == mbrc_pkg::FN_READ_HOLDING) begin
			if (p == 2) begin
				rx_count = b;
				if (int'(b >> 1) > MAX_REGS) begin
					ignoring = 1'b1;
					post_result(mbrc_pkg::ST_TOO_MANY, 16'd0, 16'd0, 1'b1);
					return;
				end
			end
			len = 5 + int'(rx_count);
		end else begin
			len = 8;
		end
		if (p < len - 2) begin
			crc_run = crc16_next(crc_run, b);
			if (rx_func == mbrc_pkg::FN_READ_HOLDING) begin
				if (p >= 3) begin
					idx = (p - 3) >> 1;
					if (idx < MAX_REGS) begin
						if (((p - 3) & 1) == 0)
							reg_buf[idx] = {b, 8'h00};
						else
							reg_buf[idx] = reg_buf[idx] | {8'h00, b};
					end
				end
			end else begin
				case (p)
					2: echo_a = {b, 8'h00};
					3: echo_a = echo_a | {8'h00, b};
					4: echo_b = {b, 8'h00};
					default: echo_b = echo_b | {8'h00, b};
				endcase
			end
		end else if (p == len - 2) begin
			rx_crc = {8'h00, b};
		end else begin
			rx_crc = rx_crc | {b, 8'h00};
			pos = p + 1;
			close_frame();
			return;
		end
		pos = p + 1;
	endtask

	// No idling during the first part of each repeating window of the run.
	function automatic bit lull();
		return (cycle_count % 3000) >= 800 && $urandom_range(0, 99) < 6;
	endfunction

	// Sender: offers queued bytes and predicts each accepted transaction.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				absorb_byte(s_axis_tdata, s_axis_tuser);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (rx_queue.size() != 0 && !lull()) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= rx_queue[0].data;
					s_axis_tuser <= rx_queue[0].first;
					void'(rx_queue.pop_front());
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// One long receiver hold-off, armed once by the stimulus.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end
	end

	task automatic compare_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, what, want, got);
		end
	endtask

	// Receiver: checks every result transaction against the oldest prediction.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, expected nothing, got %0h/%0h",
						$time, m_axis_tuser, m_axis_tdata);
				end else begin
					seen_want = due_results.pop_front();
					compare_field("status", 16'(seen_want.status), 16'(m_axis_tuser));
					compare_field("slave_id", 16'(seen_want.slave), 16'(m_axis_tdata[7:0]));
					compare_field("reg_number", seen_want.reg_num, m_axis_tdata[23:8]);
					compare_field("reg_value", seen_want.reg_val, m_axis_tdata[39:24]);
					compare_field("last", 16'(seen_want.last), 16'(m_axis_tlast));
				end
			end
			m_axis_tready <= (hold_left == 0) && !lull();
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("modbus_rtu_response_checker: mismatch");
			$finish;
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic first, input bit counted);
		rx_queue.push_back('{data: b, first: first});
		if (counted)
			stim_count++;
	endtask

	// Bytes after a frame has ended; the checker ignores them.
	task automatic queue_noise(input int n);
		repeat (n)
			queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
	endtask

	// Append the CRC to the frame body and queue the first keep bytes (all if negative).
	task automatic ship_frame(input bit bad_crc, input logic mark, input int keep);
		logic [15:0] crc;
		int          n;
		crc = mbrc_pkg::CRC_INIT;
		foreach (frame_body[i])
			crc = crc16_next(crc, frame_body[i]);
		if (bad_crc)
			crc = crc ^ 16'($urandom_range(1, 65535));
		frame_body.push_back(crc[7:0]);
		frame_body.push_back(crc[15:8]);
		n = (keep < 0 || keep > frame_body.size()) ? frame_body.size() : keep;
		for (int i = 0; i < n; i++)
			queue_byte(frame_body[i], mark && i == 0, 1'b1);
		frame_body.delete();
	endtask

	// Response body built around the current request, with optional faults.
	task automatic build_frame(input logic [7:0] sl, input logic [7:0] fn, input bit tidy);
		logic [7:0]  bc;
		logic [15:0] fa;
		logic [15:0] fb;
		frame_body = {sl, fn};
		if (fn == mbrc_pkg::FN_READ_HOLDING) begin
			if (!tidy && $urandom_range(0, 5) == 0)
				bc = 8'($urandom_range(0, 2 * MAX_REGS + 1));
			else if (cfg_count <= MAX_REGS)
				bc = 8'(2 * cfg_count);
			else
				bc = 8'(2 * $urandom_range(0, 3));
			frame_body.push_back(bc);
			repeat (bc)
				frame_body.push_back(8'($urandom_range(0, 255)));
		end else begin
			fa = cfg_start;
			fb = (fn == mbrc_pkg::FN_WRITE_SINGLE) ? cfg_value : cfg_count;
			if (!tidy && $urandom_range(0, 7) == 0)
				fa = fa ^ 16'(1 << $urandom_range(0, 15));
			if (!tidy && $urandom_range(0, 7) == 0)
				fb = fb ^ 16'(1 << $urandom_range(0, 15));
			frame_body.push_back(fa[15:8]);
			frame_body.push_back(fa[7:0]);
			frame_body.push_back(fb[15:8]);
			frame_body.push_back(fb[7:0]);
		end
	endtask

	// Mostly well-formed responses, some with faulty fields or CRCs; the rest are
	// truncated, trailed by noise, unsupported or oversized.
	task automatic random_frame(input bit tidy);
		int         roll;
		logic [7:0] sl;
		logic [7:0] fn;
		bit         bad;
		roll = tidy ? 0 : $urandom_range(0, 99);
		sl = cfg_slave;
		if (!tidy && $urandom_range(0, 9) == 0)
			sl = 8'($urandom_range(0, 255));
		fn = cfg_func;
		if (!(fn inside {mbrc_pkg::FN_READ_HOLDING, mbrc_pkg::FN_WRITE_SINGLE,
				mbrc_pkg::FN_WRITE_MULTI}) || (!tidy && $urandom_range(0, 7) == 0)) begin
			case ($urandom_range(0, 2))
				0: fn = mbrc_pkg::FN_READ_HOLDING;
				1: fn = mbrc_pkg::FN_WRITE_SINGLE;
				default: fn = mbrc_pkg::FN_WRITE_MULTI;
			endcase
		end
		bad = !tidy && $urandom_range(0, 9) == 0;
		if (roll < 80) begin
			build_frame(sl, fn, tidy);
			ship_frame(bad, 1'b1, (roll >= 72) ? $urandom_range(1, frame_body.size() + 1) : -1);
			if (roll >= 66 && roll < 72)
				queue_noise($urandom_range(1, 4));
		end else if (roll < 90) begin
			do
				fn = 8'($urandom_range(0, 255));
			while (fn inside {mbrc_pkg::FN_READ_HOLDING, mbrc_pkg::FN_WRITE_SINGLE,
				mbrc_pkg::FN_WRITE_MULTI});
			frame_body = {sl, fn};
			ship_frame(1'b0, 1'b1, 2);
			queue_noise($urandom_range(0, 3));
		end else begin
			frame_body = {sl, mbrc_pkg::FN_READ_HOLDING,
				8'($urandom_range(2 * MAX_REGS + 2, 255))};
			ship_frame(1'b0, 1'b1, 3);
			queue_noise($urandom_range(0, 3));
		end
	endtask

	task automatic write_cfg(input logic [mbrc_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			mbrc_pkg::REG_EXPECTED_SLAVE:   cfg_slave = val[7:0];
			mbrc_pkg::REG_REQUEST_FUNCTION: cfg_func = val[7:0];
			mbrc_pkg::REG_START_REGISTER:   cfg_start = val;
			mbrc_pkg::REG_REQUEST_COUNT:    cfg_count = val;
			mbrc_pkg::REG_WRITTEN_VALUE:    cfg_value = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every byte is taken and every result seen, then let the pipe settle.
	task automatic wait_idle();
		while (rx_queue.size() != 0 || s_axis_tvalid || due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One request setting, a run of random responses, and a clean final frame.
	task automatic run_phase(input logic [7:0] sl, input logic [7:0] fn, input logic [15:0] start,
			input logic [15:0] count, input logic [15:0] value, input int budget, input bit squeeze);
		int goal;
		write_cfg(mbrc_pkg::REG_EXPECTED_SLAVE, {8'h00, sl});
		write_cfg(mbrc_pkg::REG_REQUEST_FUNCTION, {8'h00, fn});
		write_cfg(mbrc_pkg::REG_START_REGISTER, start);
		write_cfg(mbrc_pkg::REG_REQUEST_COUNT, count);
		write_cfg(mbrc_pkg::REG_WRITTEN_VALUE, value);
		if (squeeze) begin
			@(negedge clk);
			hold_go = 1'b1;
		end
		goal = stim_count + budget;
		while (stim_count < goal)
			random_frame(1'b0);
		random_frame(1'b1);
		wait_idle();
	endtask

	function automatic logic [7:0] any_function();
		case ($urandom_range(0, 3))
			0: return mbrc_pkg::FN_READ_HOLDING;
			1: return mbrc_pkg::FN_WRITE_SINGLE;
			2: return mbrc_pkg::FN_WRITE_MULTI;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames against the reset request (slave 1, read of one register).
		// The first frame comes without a frame start flag.
		frame_body = {8'h01, mbrc_pkg::FN_READ_HOLDING, 8'h02, 8'hFF, 8'h00};
		ship_frame(1'b0, 1'b0, -1);
		// Unsupported function, followed by a byte that must be ignored.
		frame_body = {8'h01, 8'h00};
		ship_frame(1'b0, 1'b1, 2);
		queue_noise(1);
		// Byte count too large for the buffer.
		frame_body = {8'hFF, mbrc_pkg::FN_READ_HOLDING, 8'h42};
		ship_frame(1'b0, 1'b1, 3);
		// Write echo that does not match the pending read request.
		frame_body = {8'h01, mbrc_pkg::FN_WRITE_SINGLE, 8'h00, 8'h00, 8'h00, 8'h00};
		ship_frame(1'b0, 1'b1, -1);
		// Broken CRC on a write-multiple echo.
		frame_body = {8'h01, mbrc_pkg::FN_WRITE_MULTI, 8'h00, 8'h00, 8'h00, 8'h01};
		ship_frame(1'b1, 1'b1, -1);
		wait_idle();

		// Register number wrap, with the long receiver stall.
		run_phase(8'h00, mbrc_pkg::FN_READ_HOLDING, 16'hFFFE, 16'd4, 16'h0000, 20, 1'b1);
		run_phase(8'hFF, mbrc_pkg::FN_WRITE_SINGLE, 16'hFFFF, 16'd0, 16'hFFFF, 12, 1'b0);
		run_phase(8'($urandom_range(0, 255)), mbrc_pkg::FN_WRITE_MULTI,
			16'($urandom_range(0, 65535)), 16'hFFFF, 16'($urandom_range(0, 65535)), 12, 1'b0);
		// Full buffer reads.
		run_phase(8'($urandom_range(0, 255)), mbrc_pkg::FN_READ_HOLDING,
			16'($urandom_range(0, 65535)), 16'(MAX_REGS), 16'($urandom_range(0, 65535)), 4,
			1'b0);
		// Reads of zero registers.
		run_phase(8'($urandom_range(0, 255)), mbrc_pkg::FN_READ_HOLDING,
			16'($urandom_range(0, 65535)), 16'd0, 16'($urandom_range(0, 65535)), 10, 1'b0);
		// A write past the register list changes nothing.
		write_cfg(REG_UNUSED, 16'($urandom_range(0, 65535)));
		repeat (3)
			run_phase(8'($urandom_range(0, 255)), any_function(), 16'($urandom_range(0, 65535)),
				16'($urandom_range(1, 4)), 16'($urandom_range(0, 65535)), 10, 1'b0);

		if (errors == 0)
			$display("modbus_rtu_response_checker: match");
		else
			$display("modbus_rtu_response_checker: mismatch");
		$finish;
	end

endmodule

@@ sim.f @@
src/mbrc_pkg.sv
src/mbrc_fifo.sv
src/mbrc_front.sv
src/mbrc_back.sv
src/modbus_rtu_response_checker.sv
dv/modbus_rtu_response_checker_tb.sv
